// ===== hdl/egcm_pkg.sv =====
// Shared types and codes for the egress clause match filter.
// No dependencies; used by every module of the block.
`default_nettype none

package egcm_pkg;

	// Item operation codes
	localparam logic OP_CHECK = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Match kinds of the address, port and protocol fields
	localparam logic [1:0] KIND_ANY   = 2'd0;
	localparam logic [1:0] KIND_EXACT = 2'd1;
	localparam logic [1:0] KIND_CIDR  = 2'd2;
	localparam logic [1:0] KIND_RANGE = 2'd2;

	// Register indexes on the configuration port
	localparam logic REG_ENFORCE = 1'b0;
	localparam logic REG_COUNT   = 1'b1;

	localparam logic [31:0] FULL_MASK = 32'hffff_ffff;
	localparam logic [5:0]  ADDR_BITS = 6'd32;

	// One clause row, 102 bits; all zeros matches everything
	typedef struct packed {
		logic [1:0]  ip_kind;
		logic [7:0]  mask_len;
		logic [1:0]  port_mode;
		logic [1:0]  proto_mode;
		logic [31:0] ip_addr;
		logic [15:0] port_num;
		logic [15:0] port_low;
		logic [15:0] port_high;
		logic [7:0]  proto_num;
	} egcm_row_t;

	// Connection key of a check word
	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
		logic [7:0]  proto;
	} egcm_key_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} egcm_state_t;

endpackage

`default_nettype wire

// ===== hdl/egcm_table.sv =====
// Clause row memory: one write port, one read port with registered data.
// Depends on egcm_pkg for the row type.
`default_nettype none

module egcm_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     waddr,
	input  wire egcm_pkg::egcm_row_t wdata,
	input  wire logic              re,
	input  wire logic [AW-1:0]     raddr,
	output egcm_pkg::egcm_row_t    rdata
);

	egcm_pkg::egcm_row_t mem_q [DEPTH];

	// Store one row
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Fetch one row into the read register
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/egcm_match.sv =====
// Shared compare unit: tests one clause row against the connection key.
// Depends on egcm_pkg for row, key and kind codes.
`default_nettype none

module egcm_match (
	input  wire egcm_pkg::egcm_row_t row,
	input  wire egcm_pkg::egcm_key_t key,
	output logic                     hit
);

	logic        ip_hit;
	logic        port_hit;
	logic        proto_hit;
	logic [31:0] mask;
	logic [5:0]  shamt;

	// Network mask for prefix lengths 1 to 32
	assign shamt = egcm_pkg::ADDR_BITS - row.mask_len[5:0];
	assign mask  = egcm_pkg::FULL_MASK << shamt;

	// Address test
	always_comb begin
		case (row.ip_kind)
			egcm_pkg::KIND_ANY:   ip_hit = 1'b1;
			egcm_pkg::KIND_EXACT: ip_hit = (key.ip == row.ip_addr);
			egcm_pkg::KIND_CIDR: begin
				if (row.mask_len == 8'd0) begin
					ip_hit = 1'b1;
				end else if (row.mask_len > 8'(egcm_pkg::ADDR_BITS)) begin
					ip_hit = 1'b0;
				end else begin
					ip_hit = ((key.ip & mask) == (row.ip_addr & mask));
				end
			end
			default: ip_hit = 1'b0;
		endcase
	end

	// Port test; an empty range matches nothing by itself
	always_comb begin
		case (row.port_mode)
			egcm_pkg::KIND_ANY:   port_hit = 1'b1;
			egcm_pkg::KIND_EXACT: port_hit = (key.port == row.port_num);
			egcm_pkg::KIND_RANGE: port_hit = (key.port >= row.port_low) &&
			                                 (key.port <= row.port_high);
			default: port_hit = 1'b0;
		endcase
	end

	// Protocol test
	always_comb begin
		case (row.proto_mode)
			egcm_pkg::KIND_ANY:   proto_hit = 1'b1;
			egcm_pkg::KIND_EXACT: proto_hit = (key.proto == row.proto_num);
			default: proto_hit = 1'b0;
		endcase
	end

	assign hit = ip_hit && port_hit && proto_hit;

endmodule

`default_nettype wire

// ===== hdl/egress_clause_match_filter.sv =====
// Top level of the egress clause match filter: sequencer, registers, output word.
// Depends on egcm_pkg, egcm_table and egcm_match.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------------------------
//  req      | req_valid / req_stall   | operation, clause_index, ip_kind ... proto_num
//  rsp      | rsp_valid / rsp_stall   | allow
//  apb      | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// A write word is taken in idle. A check word scans the counted rows one row per cycle
// (through the single memory read port and compare unit), stops early on a hit, and
// skips the scan when enforcement is off or the count is zero.
// After reset the table is cleared one row a cycle, through every row; no word is
// taken meanwhile, configuration writes are. A stalled verdict holds the sequencer.
`default_nettype none

module egress_clause_match_filter #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// request words
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        operation,
	input  wire logic [5:0]  clause_index,
	input  wire logic [1:0]  ip_kind,
	input  wire logic [7:0]  mask_len,
	input  wire logic [1:0]  port_mode,
	input  wire logic [1:0]  proto_mode,
	input  wire logic [31:0] ip_addr,
	input  wire logic [15:0] port_num,
	input  wire logic [15:0] port_low,
	input  wire logic [15:0] port_high,
	input  wire logic [7:0]  proto_num,
	// verdict words
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic             allow
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = ((AW > 7) ? AW : 7) + 1;

	egcm_pkg::egcm_state_t state_q, state_d;

	logic                en_q;
	logic [6:0]          count_q;
	logic [AW-1:0]       clr_q;
	logic [CW-1:0]       issue_q;
	logic                rd_vld_s1;
	logic [CW-1:0]       rd_idx_s1;
	logic                verdict_q;
	logic                rsp_valid_q;
	logic                allow_q;
	egcm_pkg::egcm_key_t key_q;

	logic                cfg_wr;
	logic                req_acc;
	logic                idx_ok;
	logic                clr_last;
	logic [CW-1:0]       n_rows;
	logic                issue;
	logic                hit;
	logic                scan_end;
	logic                out_load;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	egcm_pkg::egcm_row_t mem_wdata;
	egcm_pkg::egcm_row_t wr_row;
	egcm_pkg::egcm_row_t rd_row;
	logic                rd_en;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign req_acc  = req_valid && !req_stall;
	assign idx_ok   = (32'(clause_index) < 32'(TABLE_DEPTH));
	assign clr_last = (clr_q == AW'(TABLE_DEPTH - 1));
	assign n_rows   = CW'(count_q);
	assign issue    = (issue_q < n_rows);
	assign scan_end = rd_vld_s1 && (hit || (rd_idx_s1 == n_rows - CW'(1)));

	assign wr_row = '{ip_kind: ip_kind, mask_len: mask_len, port_mode: port_mode,
	                  proto_mode: proto_mode, ip_addr: ip_addr, port_num: port_num,
	                  port_low: port_low, port_high: port_high, proto_num: proto_num};

	// Configuration registers; count saturates at the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			count_q <= 7'd0;
		end else if (cfg_wr) begin
			case (paddr[2])
				egcm_pkg::REG_ENFORCE: en_q <= pwdata[0];
				egcm_pkg::REG_COUNT: begin
					if (32'(pwdata[6:0]) > 32'(TABLE_DEPTH)) begin
						count_q <= 7'(TABLE_DEPTH);
					end else begin
						count_q <= pwdata[6:0];
					end
				end
				default: en_q <= en_q;
			endcase
		end
	end

	// Register readback for word-aligned addresses
	always_comb begin
		prdata = 32'd0;
		if (paddr[1:0] == 2'd0) begin
			case (paddr[2])
				egcm_pkg::REG_ENFORCE: prdata = {31'd0, en_q};
				egcm_pkg::REG_COUNT:   prdata = {25'd0, count_q};
				default:               prdata = 32'd0;
			endcase
		end
	end

	egcm_table #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW)
	) u_table (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (rd_en),
		.raddr(issue_q[AW-1:0]),
		.rdata(rd_row)
	);

	egcm_match u_match (
		.row(rd_row),
		.key(key_q),
		.hit(hit)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			egcm_pkg::ST_CLEAR: begin
				if (clr_last) begin
					state_d = egcm_pkg::ST_IDLE;
				end
			end
			egcm_pkg::ST_IDLE: begin
				if (req_acc && (operation == egcm_pkg::OP_CHECK)) begin
					if (!en_q || (count_q == 7'd0)) begin
						state_d = egcm_pkg::ST_DONE;
					end else begin
						state_d = egcm_pkg::ST_SCAN;
					end
				end
			end
			egcm_pkg::ST_SCAN: begin
				if (scan_end) begin
					state_d = egcm_pkg::ST_DONE;
				end
			end
			egcm_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = egcm_pkg::ST_IDLE;
				end
			end
			default: state_d = egcm_pkg::ST_CLEAR;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req_stall = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = AW'(clause_index);
		mem_wdata = wr_row;
		rd_en     = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			egcm_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			egcm_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				mem_we    = req_valid && (operation == egcm_pkg::OP_WRITE) && idx_ok;
			end
			egcm_pkg::ST_SCAN: begin
				rd_en = issue;
			end
			egcm_pkg::ST_DONE: begin
				out_load = !rsp_valid_q || !rsp_stall;
			end
			default: req_stall = 1'b1;
		endcase
	end

	// Control state: state, clear sweep, scan pipeline, verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= egcm_pkg::ST_CLEAR;
			clr_q     <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			verdict_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			if (state_q == egcm_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == egcm_pkg::ST_IDLE) begin
				issue_q   <= '0;
				verdict_q <= !en_q;
			end else if (rd_en) begin
				issue_q <= issue_q + CW'(1);
			end
			if ((state_q == egcm_pkg::ST_SCAN) && scan_end) begin
				verdict_q <= hit;
			end
		end
	end

	// Row index and key follow the data, no reset needed
	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q;
		if (req_acc) begin
			key_q <= '{ip: ip_addr, port: port_num, proto: proto_num};
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			allow_q <= verdict_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign allow     = allow_q;

	// A check with enforcement off goes straight to an allow verdict
	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (operation == egcm_pkg::OP_CHECK) && !en_q)
		|=> (state_q == egcm_pkg::ST_DONE) && verdict_q)
		else $error("bypass check did not produce allow");

	// Scan never issues past the clause count
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == egcm_pkg::ST_SCAN) |-> (issue_q <= n_rows))
		else $error("scan issued beyond clause count");

	// Clear sweep ends in idle after the last row
	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == egcm_pkg::ST_CLEAR) && clr_last) |=> (state_q == egcm_pkg::ST_IDLE))
		else $error("clear sweep did not finish");

endmodule

`default_nettype wire
